// ----- rtl/csc_pkg.sv -----
// ----------------------------------------------------------------------------
// csc_pkg
// Shared constants for the capsule versus sphere collision pipeline.
// ----------------------------------------------------------------------------
package csc_pkg;

    // spatial axes handled by every lane of the datapath
    localparam int AXES = 3;

endpackage

// ----- rtl/capsule_sphere_collision_test.sv -----
// Throughput: one request per cycle while the output is not stalled; the projection
// divider is unrolled into T_FRAC_BITS restoring stages, one quotient bit per stage.
// A stall at the output freezes the whole pipeline in place.
// Reset (aresetn, synchronous, active low) clears every stage valid bit.
// ----------------------------------------------------------------------------
// capsule_sphere_collision_test
// Pipelined exact capsule/sphere overlap test on Q16.8 fixed point inputs.
// ----------------------------------------------------------------------------
module capsule_sphere_collision_test #(
    parameter int COORD_BITS  = 24,
    parameter int T_FRAC_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_top_x,
    input  logic signed [COORD_BITS-1:0] s_top_y,
    input  logic signed [COORD_BITS-1:0] s_top_z,
    input  logic signed [COORD_BITS-1:0] s_bottom_x,
    input  logic signed [COORD_BITS-1:0] s_bottom_y,
    input  logic signed [COORD_BITS-1:0] s_bottom_z,
    input  logic        [COORD_BITS-2:0] s_capsule_radius,
    input  logic signed [COORD_BITS-1:0] s_ball_x,
    input  logic signed [COORD_BITS-1:0] s_ball_y,
    input  logic signed [COORD_BITS-1:0] s_ball_z,
    input  logic        [COORD_BITS-2:0] s_ball_radius,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_hit
);

    localparam int AX  = csc_pkg::AXES;
    localparam int CW  = COORD_BITS;
    localparam int TW  = T_FRAC_BITS;
    localparam int DW  = CW + 1;          // d and w components
    localparam int PRW = 2 * DW;          // component products
    localparam int LW  = 2 * CW + 2;      // d.d
    localparam int PW  = 2 * CW + 3;      // w.d, signed
    localparam int RW  = CW;              // radius sum
    localparam int QW  = TW + 1;          // clamped t
    localparam int FW  = DW + QW + 1;     // d * t
    localparam int EW  = CW + TW + 3;     // scaled offset to closest point
    localparam int MW  = EW - 1;
    localparam int HL  = MW / 2;
    localparam int HH  = MW - HL;
    localparam int SQW = 2 * MW;
    localparam int DSW = SQW + 2;
    localparam int RRW = 2 * RW + 2 * TW;

    logic en;
    assign en      = m_ready || !m_valid;
    assign s_ready = en;

    logic signed [CW-1:0] top_c [AX];
    logic signed [CW-1:0] bot_c [AX];
    logic signed [CW-1:0] ball_c [AX];

    always_comb begin
        top_c[0]  = s_top_x;
        top_c[1]  = s_top_y;
        top_c[2]  = s_top_z;
        bot_c[0]  = s_bottom_x;
        bot_c[1]  = s_bottom_y;
        bot_c[2]  = s_bottom_z;
        ball_c[0] = s_ball_x;
        ball_c[1] = s_ball_y;
        ball_c[2] = s_ball_z;
    end

    // stage a: segment and ball offsets
    logic                 v_a_reg;
    logic signed [DW-1:0] d_a_reg [AX];
    logic signed [DW-1:0] w_a_reg [AX];
    logic        [RW-1:0] rsum_a_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_a_reg <= 1'b0;
        end else if (en) begin
            v_a_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < AX; i++) begin
                d_a_reg[i] <= DW'(bot_c[i]) - DW'(top_c[i]);
                w_a_reg[i] <= DW'(ball_c[i]) - DW'(top_c[i]);
            end
            rsum_a_reg <= {1'b0, s_capsule_radius} + {1'b0, s_ball_radius};
        end
    end

    // stage b: component products
    logic                   v_b_reg;
    logic signed [PRW-1:0]  dd_b_reg [AX];
    logic signed [PRW-1:0]  wd_b_reg [AX];
    logic signed [DW-1:0]   d_b_reg [AX];
    logic signed [DW-1:0]   w_b_reg [AX];
    logic        [2*RW-1:0] rsq_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_b_reg <= 1'b0;
        end else if (en) begin
            v_b_reg <= v_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < AX; i++) begin
                dd_b_reg[i] <= d_a_reg[i] * d_a_reg[i];
                wd_b_reg[i] <= w_a_reg[i] * d_a_reg[i];
                d_b_reg[i]  <= d_a_reg[i];
                w_b_reg[i]  <= w_a_reg[i];
            end
            rsq_b_reg <= rsum_a_reg * rsum_a_reg;
        end
    end

    // stage c: dot products
    logic                   v_c_reg;
    logic        [LW-1:0]   len_c_reg;
    logic signed [PW-1:0]   dot_c_reg;
    logic signed [DW-1:0]   d_c_reg [AX];
    logic signed [DW-1:0]   w_c_reg [AX];
    logic        [2*RW-1:0] rsq_c_reg;
    logic        [LW-1:0]   len_next;
    logic signed [PW-1:0]   dot_next;

    always_comb begin
        len_next = '0;
        dot_next = '0;
        for (int i = 0; i < AX; i++) begin
            len_next = len_next + LW'(unsigned'(dd_b_reg[i][PRW-2:0]));
            dot_next = dot_next + PW'(wd_b_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_c_reg <= 1'b0;
        end else if (en) begin
            v_c_reg <= v_b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            len_c_reg <= len_next;
            dot_c_reg <= dot_next;
            d_c_reg   <= d_b_reg;
            w_c_reg   <= w_b_reg;
            rsq_c_reg <= rsq_b_reg;
        end
    end

    // stage d and divider: clamp, then one quotient bit per stage
    logic [TW:0]            dv_v_reg;
    logic [LW-1:0]          dv_r_reg    [TW+1];
    logic [LW-1:0]          dv_len_reg  [TW+1];
    logic [TW-1:0]          dv_q_reg    [TW+1];
    logic                   dv_full_reg [TW+1];
    logic                   dv_zero_reg [TW+1];
    logic signed [DW-1:0]   dv_d_reg    [TW+1][AX];
    logic signed [DW-1:0]   dv_w_reg    [TW+1][AX];
    logic [2*RW-1:0]        dv_rsq_reg  [TW+1];
    logic                   zero_next;
    logic                   full_next;

    always_comb begin
        zero_next = (len_c_reg == '0) || (dot_c_reg <= 0);
        full_next = !zero_next && ($signed({1'b0, len_c_reg}) <= dot_c_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_v_reg[0] <= 1'b0;
        end else if (en) begin
            dv_v_reg[0] <= v_c_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_r_reg[0]    <= (zero_next || full_next) ? '0 : dot_c_reg[LW-1:0];
            dv_len_reg[0]  <= len_c_reg;
            dv_q_reg[0]    <= '0;
            dv_full_reg[0] <= full_next;
            dv_zero_reg[0] <= zero_next;
            dv_d_reg[0]    <= d_c_reg;
            dv_w_reg[0]    <= w_c_reg;
            dv_rsq_reg[0]  <= rsq_c_reg;
        end
    end

    for (genvar k = 0; k < TW; k++) begin : g_div
        logic [LW:0] r2;
        logic        ge;

        always_comb begin
            r2 = {dv_r_reg[k], 1'b0};
            ge = r2 >= {1'b0, dv_len_reg[k]};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v_reg[k+1] <= 1'b0;
            end else if (en) begin
                dv_v_reg[k+1] <= dv_v_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_r_reg[k+1]    <= ge ? LW'(r2 - {1'b0, dv_len_reg[k]}) : LW'(r2);
                dv_len_reg[k+1]  <= dv_len_reg[k];
                dv_q_reg[k+1]    <= {dv_q_reg[k][TW-2:0], ge};
                dv_full_reg[k+1] <= dv_full_reg[k];
                dv_zero_reg[k+1] <= dv_zero_reg[k];
                dv_d_reg[k+1]    <= dv_d_reg[k];
                dv_w_reg[k+1]    <= dv_w_reg[k];
                dv_rsq_reg[k+1]  <= dv_rsq_reg[k];
            end
        end
    end

    // stage f: d * t
    logic [QW-1:0]          tq;
    logic                   v_f_reg;
    logic signed [FW-1:0]   dtq_f_reg [AX];
    logic signed [DW-1:0]   w_f_reg [AX];
    logic [2*RW-1:0]        rsq_f_reg;

    always_comb begin
        if (dv_full_reg[TW]) begin
            tq = QW'(1) << TW;
        end else if (dv_zero_reg[TW]) begin
            tq = '0;
        end else begin
            tq = {1'b0, dv_q_reg[TW]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_f_reg <= 1'b0;
        end else if (en) begin
            v_f_reg <= dv_v_reg[TW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < AX; i++) begin
                dtq_f_reg[i] <= FW'(dv_d_reg[TW][i]) * FW'(signed'({1'b0, tq}));
            end
            w_f_reg   <= dv_w_reg[TW];
            rsq_f_reg <= dv_rsq_reg[TW];
        end
    end

    // stage g: magnitude of the scaled offset
    logic                 v_g_reg;
    logic [MW-1:0]        mag_g_reg [AX];
    logic [2*RW-1:0]      rsq_g_reg;
    logic signed [EW-1:0] e_next [AX];

    always_comb begin
        for (int i = 0; i < AX; i++) begin
            e_next[i] = (EW'(w_f_reg[i]) <<< TW) - EW'(dtq_f_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_g_reg <= 1'b0;
        end else if (en) begin
            v_g_reg <= v_f_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < AX; i++) begin
                mag_g_reg[i] <= e_next[i][EW-1] ? MW'(-e_next[i]) : MW'(e_next[i]);
            end
            rsq_g_reg <= rsq_f_reg;
        end
    end

    // stage h: split squares into half-width partial products
    logic              v_h_reg;
    logic [2*HL-1:0]   pll_h_reg [AX];
    logic [HL+HH-1:0]  plh_h_reg [AX];
    logic [2*HH-1:0]   phh_h_reg [AX];
    logic [2*RW-1:0]   rsq_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_h_reg <= 1'b0;
        end else if (en) begin
            v_h_reg <= v_g_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < AX; i++) begin
                pll_h_reg[i] <= (2*HL)'(mag_g_reg[i][HL-1:0])
                              * (2*HL)'(mag_g_reg[i][HL-1:0]);
                plh_h_reg[i] <= (HL+HH)'(mag_g_reg[i][HL-1:0])
                              * (HL+HH)'(mag_g_reg[i][MW-1:HL]);
                phh_h_reg[i] <= (2*HH)'(mag_g_reg[i][MW-1:HL])
                              * (2*HH)'(mag_g_reg[i][MW-1:HL]);
            end
            rsq_h_reg <= rsq_g_reg;
        end
    end

    // stage i: recombine each square
    logic             v_i_reg;
    logic [SQW-1:0]   sq_i_reg [AX];
    logic [2*RW-1:0]  rsq_i_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_i_reg <= 1'b0;
        end else if (en) begin
            v_i_reg <= v_h_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < AX; i++) begin
                sq_i_reg[i] <= (SQW'(phh_h_reg[i]) << (2*HL))
                             + (SQW'(plh_h_reg[i]) << (HL+1))
                             + SQW'(pll_h_reg[i]);
            end
            rsq_i_reg <= rsq_h_reg;
        end
    end

    // stage j: squared distance and scaled squared radius sum
    logic            v_j_reg;
    logic [DSW-1:0]  dist_j_reg;
    logic [DSW-1:0]  rr_j_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_j_reg <= 1'b0;
        end else if (en) begin
            v_j_reg <= v_i_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dist_j_reg <= DSW'(sq_i_reg[0]) + DSW'(sq_i_reg[1]) + DSW'(sq_i_reg[2]);
            rr_j_reg   <= DSW'(RRW'(rsq_i_reg) << (2*TW));
        end
    end

    // output register
    logic m_valid_reg;
    logic m_hit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v_j_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_hit_reg <= rr_j_reg >= dist_j_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_hit   = m_hit_reg;

`ifndef SYNTHESIS
    // clamp flags are exclusive
    assert property (@(posedge aclk) disable iff (!aresetn)
        dv_v_reg[0] |-> !(dv_full_reg[0] && dv_zero_reg[0]))
        else $error("projection clamped both ways");

    // restoring remainder stays below the divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        (dv_v_reg[TW] && !dv_zero_reg[TW]) |-> (dv_r_reg[TW] < dv_len_reg[TW]))
        else $error("divider remainder out of range");

    // a stalled pipeline keeps all of its requests
    assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable({v_a_reg, v_b_reg, v_c_reg, dv_v_reg, v_f_reg, v_g_reg,
                         v_h_reg, v_i_reg, v_j_reg}))
        else $error("request lost or moved during stall");

    // a degenerate segment never projects past its end
    assert property (@(posedge aclk) disable iff (!aresetn)
        (dv_v_reg[0] && dv_len_reg[0] == '0) |-> !dv_full_reg[0])
        else $error("zero length segment clamped to end");
`endif

endmodule

// ----- tb/sv/tb_capsule_sphere_collision_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_capsule_sphere_collision_test
// Streams capsule/sphere pairs through the collision pipeline with random
// gaps and stalls, and checks every hit flag against an exact in-bench
// computation of the closest-point distance test.
// ----------------------------------------------------------------------------
module tb_capsule_sphere_collision_test;

    localparam int CB = 24;
    localparam int TF = 16;
    localparam int RANDOM_PAIRS = 1950;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [CB-1:0] tx, ty, tz, bx, by, bz;
        logic [CB-2:0] cr;
        logic [CB-1:0] px, py, pz;
        logic [CB-2:0] pr;
    } pair_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_hit;
    pair_t cur = '0;

    pair_t pending_pairs[$];
    logic hit_expected[$];
    int mismatches = 0;
    int hits_seen = 0;
    int results_seen = 0;
    int idle_cycles = 0;
    bit stim_done = 1'b0;
    bit long_hold = 1'b0;

    capsule_sphere_collision_test #(.COORD_BITS(CB), .T_FRAC_BITS(TF)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_top_x(cur.tx), .s_top_y(cur.ty), .s_top_z(cur.tz),
        .s_bottom_x(cur.bx), .s_bottom_y(cur.by), .s_bottom_z(cur.bz),
        .s_capsule_radius(cur.cr),
        .s_ball_x(cur.px), .s_ball_y(cur.py), .s_ball_z(cur.pz),
        .s_ball_radius(cur.pr),
        .m_valid(m_valid), .m_ready(m_ready), .m_hit(m_hit)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // exact overlap test, everything in wide signed integers
    function automatic logic capsule_touches_ball(pair_t p);
        logic signed [127:0] d[3], w[3], e, dd, wd, dist_sq, rr, rem;
        logic signed [127:0] top[3];
        logic [TF:0] tq;
        top[0] = $signed(p.tx); top[1] = $signed(p.ty); top[2] = $signed(p.tz);
        d[0] = $signed(p.bx) - top[0];
        d[1] = $signed(p.by) - top[1];
        d[2] = $signed(p.bz) - top[2];
        w[0] = $signed(p.px) - top[0];
        w[1] = $signed(p.py) - top[1];
        w[2] = $signed(p.pz) - top[2];
        dd = 0; wd = 0; dist_sq = 0; tq = 0;
        for (int i = 0; i < 3; i++) begin
            dd += d[i] * d[i];
            wd += w[i] * d[i];
        end
        if (dd != 0 && wd > 0) begin
            if (wd >= dd) begin
                tq = 1 << TF;
            end else begin
                rem = wd;
                for (int i = 0; i < TF; i++) begin
                    rem = rem <<< 1;
                    tq = tq << 1;
                    if (rem >= dd) begin
                        rem -= dd;
                        tq[0] = 1'b1;
                    end
                end
            end
        end
        for (int i = 0; i < 3; i++) begin
            e = (w[i] <<< TF) - d[i] * $signed({1'b0, tq});
            dist_sq += e * e;
        end
        rr = {105'b0, p.cr} + {105'b0, p.pr};
        rr = (rr * rr) <<< (2 * TF);
        return rr >= dist_sq;
    endfunction

    function automatic logic [CB-1:0] rand_coord(int mode);
        case (mode)
            0: return CB'($urandom);
            1: return CB'($signed($urandom_range(0, 2000)) - 1000);
            default: return CB'($signed($urandom_range(0, 200000)) - 100000);
        endcase
    endfunction

    function automatic pair_t rand_pair();
        pair_t p;
        int mode;
        mode = $urandom_range(0, 4);
        if (mode > 2) mode = 2;
        p.tx = rand_coord(mode); p.ty = rand_coord(mode); p.tz = rand_coord(mode);
        p.bx = rand_coord(mode); p.by = rand_coord(mode); p.bz = rand_coord(mode);
        p.px = rand_coord(mode); p.py = rand_coord(mode); p.pz = rand_coord(mode);
        if ($urandom_range(0, 9) == 0) begin
            p.bx = p.tx; p.by = p.ty; p.bz = p.tz;
        end
        if (mode == 0) begin
            p.cr = (CB-1)'($urandom); p.pr = (CB-1)'($urandom);
        end else begin
            p.cr = (CB-1)'($urandom_range(0, 60000 >> (mode == 1 ? 6 : 0)));
            p.pr = (CB-1)'($urandom_range(0, 60000 >> (mode == 1 ? 6 : 0)));
        end
        return p;
    endfunction

    function automatic pair_t make_pair(int t0, int t1, int t2, int b0, int b1, int b2,
                                        int cr, int p0, int p1, int p2, int pr);
        pair_t p;
        p.tx = CB'(t0); p.ty = CB'(t1); p.tz = CB'(t2);
        p.bx = CB'(b0); p.by = CB'(b1); p.bz = CB'(b2);
        p.cr = (CB-1)'(cr);
        p.px = CB'(p0); p.py = CB'(p1); p.pz = CB'(p2);
        p.pr = (CB-1)'(pr);
        return p;
    endfunction

    initial begin
        int mx, mn, rmax;
        mx = 8388607; mn = -8388608; rmax = 8388607;
        // zero-length segment, touching and just apart
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 256, 512, 0, 0, 256));
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 256, 513, 0, 0, 256));
        // projection before start, past end, and in the middle
        pending_pairs.push_back(make_pair(0, 0, 0, 1000, 0, 0, 10, -50, 0, 0, 40));
        pending_pairs.push_back(make_pair(0, 0, 0, 1000, 0, 0, 10, 1051, 0, 0, 40));
        pending_pairs.push_back(make_pair(0, 0, 0, 1000, 0, 0, 10, 1050, 0, 0, 40));
        pending_pairs.push_back(make_pair(0, 0, 0, 1000, 0, 0, 10, 333, 50, 0, 40));
        pending_pairs.push_back(make_pair(0, 0, 0, 1000, 0, 0, 10, 333, 51, 0, 40));
        pending_pairs.push_back(make_pair(0, 0, 0, 3, 7, 11, 0, 1, 2, 5, 0));
        // extremes of every field
        pending_pairs.push_back(make_pair(mn, mn, mn, mx, mx, mx, rmax, mx, mn, mx, rmax));
        pending_pairs.push_back(make_pair(mx, mx, mx, mn, mn, mn, 0, mn, mx, mn, 0));
        pending_pairs.push_back(make_pair(mn, mn, mn, mn, mn, mn, 0, mx, mx, mx, 0));
        pending_pairs.push_back(make_pair(mn, mn, mn, mn, mn, mn, rmax, mx, mx, mx, rmax));
        pending_pairs.push_back(make_pair(mx, 0, mn, mn, 0, mx, 1, 0, mx, 0, 1));
        pending_pairs.push_back(make_pair(-1, -1, -1, 0, 0, 0, 0, -1, -1, -1, 0));
        pending_pairs.push_back(make_pair(mn, 0, 0, mx, 0, 0, 0, 0, 1, 0, 1));
        pending_pairs.push_back(make_pair(mn, 0, 0, mx, 0, 0, 0, mx, mx, 0, rmax));
        for (int i = 0; i < RANDOM_PAIRS; i++) pending_pairs.push_back(rand_pair());
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // request driver
    int send_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                hit_expected.push_back(capsule_touches_ball(cur));
                send_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0 || pending_pairs.size() == 0) begin
                    s_valid <= 1'b0;
                    if (send_gap > 0) send_gap--;
                    if (pending_pairs.size() == 0) stim_done = 1'b1;
                end else begin
                    cur <= pending_pairs.pop_front();
                    s_valid <= 1'b1;
                end
            end
        end
    end

    task automatic report_mismatch(logic got, logic want);
        mismatches++;
        $display("mismatch on result %0d: hit %0b, expected %0b", results_seen, got, want);
    endtask

    // result monitor with random stalls and one long hold-off
    int recv_gap = 0;
    int hold_cnt = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (hit_expected.size() == 0) begin
                    // result with no request behind it
                    report_mismatch(m_hit, 1'bx);
                end else begin
                    logic want;
                    want = hit_expected.pop_front();
                    if (m_hit !== want) report_mismatch(m_hit, want);
                end
                results_seen++;
                if (m_hit === 1'b1) hits_seen++;
                recv_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
            end
            if (results_seen == 200 && !long_hold) begin
                long_hold = 1'b1;
                hold_cnt = 300;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog and end of run
    initial begin
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout with %0d results outstanding", hit_expected.size());
                $display("Verification failed");
                $finish;
            end
            if (stim_done && !s_valid && hit_expected.size() == 0) begin
                repeat (10 + TF + 10) @(posedge aclk);
                $display("%0d pairs checked, %0d hits, including a %0d-cycle output stall",
                         results_seen, hits_seen, 300);
                if (mismatches == 0 && hit_expected.size() == 0) begin
                    $display("Verification passed");
                end else begin
                    $display("Verification failed");
                end
                $finish;
            end
        end
    end

endmodule

// ----- files.f -----
rtl/csc_pkg.sv
rtl/capsule_sphere_collision_test.sv
tb/sv/tb_capsule_sphere_collision_test.sv
